FILE: rtl/vvs_pkg.sv
// ----------------------------------------------------------------------------
// vvs_pkg
// Shared types, constants and helpers of the velocity Verlet step block.
// ----------------------------------------------------------------------------
package vvs_pkg;

   localparam int unsigned DIMENSIONS_DEF = 2;
   localparam int unsigned Q_WIDTH        = 32;
   localparam int unsigned DT_WIDTH       = 16;
   localparam int unsigned MASS_WIDTH     = 32;
   localparam int unsigned DIV_STEPS      = 48;
   localparam int unsigned DIV_CNT_WIDTH  = $clog2(DIV_STEPS);
   localparam int unsigned CSR_ADDR_WIDTH = 8;
   localparam int unsigned REQ_WIDTH      = 2 * Q_WIDTH;
   localparam int unsigned RSP_WIDTH      = 6 * Q_WIDTH;

   localparam logic [DT_WIDTH-1:0]   DT_RESET   = 16'd3277;
   localparam logic [MASS_WIDTH-1:0] MASS_RESET = 32'd65536;

   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_TIME_STEP = 8'd0;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_BODY_MASS = 8'd1;

   localparam logic signed [Q_WIDTH-1:0] SAT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [Q_WIDTH-1:0] SAT_MIN = 32'sh8000_0000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_VDT,
      ST_ADT,
      ST_ADT2,
      ST_POS,
      ST_DIV,
      ST_NEWADT,
      ST_VEL,
      ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_VDT,
      OP_ADT,
      OP_ADT2,
      OP_POS,
      OP_ACC,
      OP_NEWADT,
      OP_VEL
   } lane_op_type;

   typedef struct packed {
      logic        start;
      lane_op_type op;
   } lane_ctrl_type;

   typedef struct packed {
      logic div_done;
   } lane_stat_type;

   function automatic logic signed [Q_WIDTH-1:0] sat32(input logic signed [49:0] x);
      logic signed [Q_WIDTH-1:0] r;
      if (x > 50'(SAT_MAX)) begin
         r = SAT_MAX;
      end else if (x < 50'(SAT_MIN)) begin
         r = SAT_MIN;
      end else begin
         r = x[Q_WIDTH-1:0];
      end
      return r;
   endfunction

endpackage

FILE: rtl/vvs_div.sv
// ----------------------------------------------------------------------------
// vvs_div
// Restoring divider, one quotient bit per cycle: force / mass in Q16.16,
// rounded to nearest with ties away from zero, signed and saturated.
// ----------------------------------------------------------------------------
module vvs_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [vvs_pkg::Q_WIDTH-1:0] force_val,
   input  logic [vvs_pkg::MASS_WIDTH-1:0]     body_mass,
   output logic                               done,
   output logic signed [vvs_pkg::Q_WIDTH-1:0] quotient
);
   import vvs_pkg::*;

   localparam int unsigned NUM_WIDTH = Q_WIDTH + 16;

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [DIV_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [NUM_WIDTH-1:0]     num_ff, num_in;
   logic [MASS_WIDTH-1:0]    rem_ff, rem_in;
   logic                     neg_ff, neg_in;
   logic                     zero_ff, zero_in;

   logic [Q_WIDTH-1:0]    mag;
   logic [MASS_WIDTH:0]   trial;
   logic [MASS_WIDTH+1:0] diff;
   logic                  qbit;
   logic                  round_up;
   logic [NUM_WIDTH:0]    q_round;

   assign mag   = force_val[Q_WIDTH-1] ? Q_WIDTH'(-force_val) : Q_WIDTH'(force_val);
   assign trial = {rem_ff, num_ff[NUM_WIDTH-1]};
   assign diff  = {1'b0, trial} - {2'b00, body_mass};
   assign qbit  = ~diff[MASS_WIDTH+1];

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = '0;
         num_in  = {mag, 16'd0};
         rem_in  = '0;
         neg_in  = force_val[Q_WIDTH-1];
         zero_in = (mag == '0);
      end else if (busy_ff) begin
         num_in = {num_ff[NUM_WIDTH-2:0], qbit};
         rem_in = qbit ? diff[MASS_WIDTH-1:0] : trial[MASS_WIDTH-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_WIDTH'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
   end

   // round half away from zero: bump when twice the remainder reaches the divisor
   assign round_up = ({rem_ff, 1'b0} >= {1'b0, body_mass});
   assign q_round  = {1'b0, num_ff} + (NUM_WIDTH + 1)'(round_up);

   always_comb begin
      if (zero_ff) begin
         quotient = '0;
      end else if (neg_ff) begin
         if (q_round > (NUM_WIDTH + 1)'(64'h8000_0000)) begin
            quotient = SAT_MIN;
         end else begin
            quotient = Q_WIDTH'(-q_round[Q_WIDTH-1:0]);
         end
      end else begin
         if (q_round > (NUM_WIDTH + 1)'(64'h7FFF_FFFF)) begin
            quotient = SAT_MAX;
         end else begin
            quotient = q_round[Q_WIDTH-1:0];
         end
      end
   end

   assign done = done_ff;

endmodule

FILE: rtl/vvs_lane.sv
// ----------------------------------------------------------------------------
// vvs_lane
// One dimension: position, velocity and acceleration state, a 48x16
// multiplier stepped by the controller, and the force/mass divider.
// ----------------------------------------------------------------------------
module vvs_lane (
   input  logic                               clock,
   input  logic                               reset,
   input  vvs_pkg::lane_ctrl_type             ctrl,
   input  logic [vvs_pkg::DT_WIDTH-1:0]       time_step,
   input  logic [vvs_pkg::MASS_WIDTH-1:0]     body_mass,
   input  logic signed [vvs_pkg::Q_WIDTH-1:0] force_val,
   output vvs_pkg::lane_stat_type             stat,
   output logic signed [vvs_pkg::Q_WIDTH-1:0] position,
   output logic signed [vvs_pkg::Q_WIDTH-1:0] velocity,
   output logic signed [vvs_pkg::Q_WIDTH-1:0] accel
);
   import vvs_pkg::*;

   logic signed [Q_WIDTH-1:0] pos_ff, pos_in;
   logic signed [Q_WIDTH-1:0] vel_ff, vel_in;
   logic signed [Q_WIDTH-1:0] acc_ff, acc_in;
   logic signed [63:0]        prod_ff, prod_in;
   logic signed [33:0]        t1_ff, t1_in;
   logic signed [33:0]        half_ff, half_in;

   logic signed [47:0] mul_a;
   logic signed [64:0] mul_full;
   logic signed [64:0] prod_ext;
   logic signed [64:0] sum16, sum17, sum33;
   logic signed [64:0] rnd16, rnd17, rnd33;
   logic signed [33:0] t2;
   logic               div_done;
   logic signed [Q_WIDTH-1:0] div_q;

   vvs_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (ctrl.start),
      .force_val (force_val),
      .body_mass (body_mass),
      .done      (div_done),
      .quotient  (div_q)
   );

   always_comb begin
      case (ctrl.op)
         OP_ADT, OP_NEWADT: mul_a = 48'(acc_ff);
         OP_ADT2:           mul_a = prod_ff[47:0];
         default:           mul_a = 48'(vel_ff);
      endcase
   end

   assign mul_full = 65'(mul_a) * $signed({49'd0, time_step});

   // rounding shifts: nearest, ties toward plus infinity
   assign prod_ext = 65'(prod_ff);
   assign sum16    = prod_ext + (65'sd1 <<< 15);
   assign sum17    = prod_ext + (65'sd1 <<< 16);
   assign sum33    = prod_ext + (65'sd1 <<< 32);
   assign rnd16    = sum16 >>> 16;
   assign rnd17    = sum17 >>> 17;
   assign rnd33    = sum33 >>> 33;
   assign t2       = rnd33[33:0];

   always_comb begin
      pos_in  = pos_ff;
      vel_in  = vel_ff;
      acc_in  = acc_ff;
      prod_in = prod_ff;
      t1_in   = t1_ff;
      half_in = half_ff;
      case (ctrl.op)
         OP_VDT: begin
            prod_in = mul_full[63:0];
         end
         OP_ADT: begin
            t1_in   = rnd16[33:0];
            prod_in = mul_full[63:0];
         end
         OP_ADT2: begin
            half_in = rnd17[33:0];
            prod_in = mul_full[63:0];
         end
         OP_POS: begin
            pos_in = sat32(50'(pos_ff) + 50'(t1_ff) + 50'(t2));
            vel_in = sat32(50'(vel_ff) + 50'(half_ff));
         end
         OP_ACC: begin
            acc_in = div_q;
         end
         OP_NEWADT: begin
            prod_in = mul_full[63:0];
         end
         OP_VEL: begin
            vel_in = sat32(50'(vel_ff) + 50'($signed(rnd17[33:0])));
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         vel_ff <= '0;
         acc_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         vel_ff <= vel_in;
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      t1_ff   <= t1_in;
      half_ff <= half_in;
   end

   assign stat.div_done = div_done;
   assign position      = pos_ff;
   assign velocity      = vel_ff;
   assign accel         = acc_ff;

endmodule

FILE: rtl/velocity_verlet_step.sv
// ----------------------------------------------------------------------------
// velocity_verlet_step
// Velocity Verlet timestep for one body in signed Q16.16, one lane per
// dimension, results merged into a single response register.
//
//   channel   dir  handshake              payload
//   req_      in   req_tvalid/req_tready  req_tdata: force_x, force_y
//   rsp_      out  rsp_tvalid/rsp_tready  rsp_tdata: position, velocity, accel
//   csr_      in   csr_valid/csr_ready    csr_addr, csr_wdata
//
// From acceptance to rsp_tvalid the time taken is set by the 48-step
// force/mass divider in each lane; the multiply steps up to the position update
// run beside it. One request is in flight at a time; the next is taken as soon
// as the previous result sits in the response register.
// Reset clears the state to zero and loads time_step 3277 and body_mass 1.0;
// no clearing pass. A stalled response holds the block in its last step
// until taken.
// ----------------------------------------------------------------------------
module velocity_verlet_step #(
   parameter int unsigned DIMENSIONS = vvs_pkg::DIMENSIONS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [31:0] force_x, [63:32] force_y
   input  logic [vvs_pkg::REQ_WIDTH-1:0]       req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [31:0] position_x, [63:32] position_y, [95:64] velocity_x,
   // [127:96] velocity_y, [159:128] accel_x, [191:160] accel_y
   output logic [vvs_pkg::RSP_WIDTH-1:0]       rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [vvs_pkg::CSR_ADDR_WIDTH-1:0]  csr_addr,
   input  logic [31:0]                         csr_wdata
);
   import vvs_pkg::*;

   state_type state_ff, state_in;
   logic [DT_WIDTH-1:0]   dt_ff, dt_in;
   logic [MASS_WIDTH-1:0] mass_ff, mass_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_WIDTH-1:0]  rsp_data_ff, rsp_data_in;

   lane_ctrl_type ctrl;
   lane_stat_type stat [DIMENSIONS];
   logic signed [Q_WIDTH-1:0] pos [DIMENSIONS];
   logic signed [Q_WIDTH-1:0] vel [DIMENSIONS];
   logic signed [Q_WIDTH-1:0] acc [DIMENSIONS];
   logic signed [Q_WIDTH-1:0] merged [6];
   logic req_fire;
   logic all_done;
   logic out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign csr_ready  = 1'b1;
   assign out_free   = ~rsp_valid_ff | rsp_tready;

   for (genvar i = 0; i < DIMENSIONS; i++) begin : g_lane
      logic signed [Q_WIDTH-1:0] lane_force;
      if (i < 2) begin : g_force
         assign lane_force = req_tdata[i*Q_WIDTH +: Q_WIDTH];
      end else begin : g_noforce
         assign lane_force = '0;
      end
      vvs_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .time_step (dt_ff),
         .body_mass (mass_ff),
         .force_val (lane_force),
         .stat      (stat[i]),
         .position  (pos[i]),
         .velocity  (vel[i]),
         .accel     (acc[i])
      );
   end

   always_comb begin
      all_done = 1'b1;
      for (int i = 0; i < DIMENSIONS; i++) begin
         all_done = all_done & stat[i].div_done;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_fire) state_in = ST_VDT;
         ST_VDT:    state_in = ST_ADT;
         ST_ADT:    state_in = ST_ADT2;
         ST_ADT2:   state_in = ST_POS;
         ST_POS:    state_in = ST_DIV;
         ST_DIV:    if (all_done) state_in = ST_NEWADT;
         ST_NEWADT: state_in = ST_VEL;
         ST_VEL:    state_in = ST_OUT;
         ST_OUT:    if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // lane control
   always_comb begin
      ctrl.start = req_fire;
      case (state_ff)
         ST_VDT:    ctrl.op = OP_VDT;
         ST_ADT:    ctrl.op = OP_ADT;
         ST_ADT2:   ctrl.op = OP_ADT2;
         ST_POS:    ctrl.op = OP_POS;
         ST_DIV:    ctrl.op = all_done ? OP_ACC : OP_NONE;
         ST_NEWADT: ctrl.op = OP_NEWADT;
         ST_VEL:    ctrl.op = OP_VEL;
         default:   ctrl.op = OP_NONE;
      endcase
   end

   for (genvar j = 0; j < 2; j++) begin : g_merge
      if (j < DIMENSIONS) begin : g_live
         assign merged[j]     = pos[j];
         assign merged[2 + j] = vel[j];
         assign merged[4 + j] = acc[j];
      end else begin : g_zero
         assign merged[j]     = '0;
         assign merged[2 + j] = '0;
         assign merged[4 + j] = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == ST_OUT && out_free) begin
         rsp_valid_in = 1'b1;
         for (int k = 0; k < 6; k++) begin
            rsp_data_in[k*Q_WIDTH +: Q_WIDTH] = merged[k];
         end
      end
   end

   always_comb begin
      dt_in   = dt_ff;
      mass_in = mass_ff;
      if (csr_valid && csr_ready) begin
         case (csr_addr)
            CSR_TIME_STEP: dt_in   = csr_wdata[DT_WIDTH-1:0];
            CSR_BODY_MASS: mass_in = csr_wdata[MASS_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dt_ff        <= DT_RESET;
         mass_ff      <= MASS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dt_ff        <= dt_in;
         mass_ff      <= mass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: rtl/vvs_checker.sv
// ----------------------------------------------------------------------------
// vvs_checker
// Port-level checks of the velocity Verlet step block, bound to the top.
// ----------------------------------------------------------------------------
module vvs_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [vvs_pkg::RSP_WIDTH-1:0] rsp_tdata
);
   import vvs_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("stalled response changed");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   a_no_early: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("response one cycle after request");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind velocity_verlet_step vvs_checker u_vvs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

FILE: test/tb_velocity_verlet_step.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_velocity_verlet_step
// Self-checking bench for the velocity Verlet step. A short table of forces
// and register settings comes first, then random force requests over a range
// of timestep and mass settings. Every request is run through a bench-side
// integrator and each response is compared field by field in order. The
// request side idles in bursts and the response side stalls in patterns.
// ----------------------------------------------------------------------------
module tb_velocity_verlet_step;

   localparam int BODY_DIMS   = vvs_pkg::DIMENSIONS_DEF;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int TAIL_CYCLES = 64;
   localparam int LONG_HOLD   = 400;
   localparam int PHASES      = 10;
   localparam int PHASE_ITEMS = 128;

   localparam logic [vvs_pkg::CSR_ADDR_WIDTH-1:0] REG_DT       = vvs_pkg::CSR_TIME_STEP;
   localparam logic [vvs_pkg::CSR_ADDR_WIDTH-1:0] REG_MASS     = vvs_pkg::CSR_BODY_MASS;
   localparam logic [vvs_pkg::CSR_ADDR_WIDTH-1:0] REG_SPARE_LO = 8'h02;
   localparam logic [vvs_pkg::CSR_ADDR_WIDTH-1:0] REG_SPARE_HI = 8'h81;

   localparam longint Q_MAX = longint'(vvs_pkg::SAT_MAX);
   localparam longint Q_MIN = longint'(vvs_pkg::SAT_MIN);

   typedef logic signed [vvs_pkg::Q_WIDTH-1:0] q16_t;

   localparam q16_t F_MAX = vvs_pkg::SAT_MAX;
   localparam q16_t F_MIN = vvs_pkg::SAT_MIN;
   localparam q16_t Q_ONE = 32'sh0001_0000;

   typedef struct packed {
      q16_t force_y;
      q16_t force_x;
   } force_req_t;

   typedef struct packed {
      q16_t accel_y;
      q16_t accel_x;
      q16_t velocity_y;
      q16_t velocity_x;
      q16_t position_y;
      q16_t position_x;
   } body_state_t;

   typedef struct {
      bit          write_csr;
      logic [7:0]  csr_index;
      logic [31:0] csr_value;
      q16_t        force_x;
      q16_t        force_y;
      bit          known;
      body_state_t known_state;
   } plan_row_t;

   typedef enum {RX_FREE, RX_HALF, RX_SPARSE, RX_STOP} rx_mode_t;

   logic                                clock      = 1'b0;
   logic                                reset      = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [vvs_pkg::REQ_WIDTH-1:0]       req_tdata  = '0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [vvs_pkg::RSP_WIDTH-1:0]       rsp_tdata;
   logic                                csr_valid  = 1'b0;
   logic                                csr_ready;
   logic [vvs_pkg::CSR_ADDR_WIDTH-1:0]  csr_addr   = '0;
   logic [31:0]                         csr_wdata  = '0;

   // bench copy of the integrator state and registers
   logic [vvs_pkg::DT_WIDTH-1:0]   step_dt  = vvs_pkg::DT_RESET;
   logic [vvs_pkg::MASS_WIDTH-1:0] mass_reg = vvs_pkg::MASS_RESET;
   longint body_pos[3] = '{0, 0, 0};
   longint body_vel[3] = '{0, 0, 0};
   longint body_acc[3] = '{0, 0, 0};

   body_state_t expected_q[$];
   plan_row_t   directed_plan[$];

   int       mismatch_count  = 0;
   int       results_checked = 0;
   int       requests_sent   = 0;
   int       csr_writes      = 0;
   int       hold_ask        = 0;
   int       hold_seen       = 0;
   int       hold_left       = 0;
   int       rx_run          = 0;
   rx_mode_t rx_mode         = RX_FREE;
   int       burst_left      = 0;
   bit       gaps_on         = 1'b1;
   longint   cycle_count     = 0;

   string field_name[6] = '{"position_x", "position_y", "velocity_x", "velocity_y",
                            "accel_x", "accel_y"};

   velocity_verlet_step #(
      .DIMENSIONS (BODY_DIMS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   // nearest, ties toward plus infinity
   function automatic longint round_q(input longint x, input int s);
      return (x + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint clamp_q(input longint x);
      if (x > Q_MAX) return Q_MAX;
      if (x < Q_MIN) return Q_MIN;
      return x;
   endfunction

   // force/mass, nearest with ties away from zero, then saturated
   function automatic longint accel_from_force(input longint f);
      longint unsigned mag;
      longint unsigned quo;
      longint unsigned m;
      m = mass_reg;
      if (m == 0) return (f == 0) ? 0 : ((f < 0) ? Q_MIN : Q_MAX);
      mag = (f < 0) ? -f : f;
      mag = mag << 16;
      quo = (2 * mag + m) / (2 * m);
      if (f < 0) return (quo > 64'd2147483648) ? Q_MIN : -longint'(quo);
      return (quo > 64'd2147483647) ? Q_MAX : longint'(quo);
   endfunction

   function automatic body_state_t advance_body(input q16_t fx, input q16_t fy);
      longint      dt;
      longint      force_in;
      body_state_t r;
      int          i;
      dt = longint'(step_dt);
      for (i = 0; i < BODY_DIMS; i++)
         body_pos[i] = clamp_q(body_pos[i] + round_q(body_vel[i] * dt, 16)
                               + round_q(body_acc[i] * dt * dt, 33));
      for (i = 0; i < BODY_DIMS; i++)
         body_vel[i] = clamp_q(body_vel[i] + round_q(body_acc[i] * dt, 17));
      for (i = 0; i < BODY_DIMS; i++) begin
         force_in = (i == 0) ? fx : ((i == 1) ? fy : 32'sd0);
         body_acc[i] = accel_from_force(force_in);
      end
      for (i = 0; i < BODY_DIMS; i++)
         body_vel[i] = clamp_q(body_vel[i] + round_q(body_acc[i] * dt, 17));
      r = '0;
      r.position_x = q16_t'(body_pos[0]);
      r.velocity_x = q16_t'(body_vel[0]);
      r.accel_x    = q16_t'(body_acc[0]);
      if (BODY_DIMS > 1) begin
         r.position_y = q16_t'(body_pos[1]);
         r.velocity_y = q16_t'(body_vel[1]);
         r.accel_y    = q16_t'(body_acc[1]);
      end
      return r;
   endfunction

   // body at rest at the origin, only the acceleration set
   function automatic body_state_t still_body(input q16_t ax, input q16_t ay);
      body_state_t r;
      r = '0;
      r.accel_x = ax;
      r.accel_y = ay;
      return r;
   endfunction

   function automatic q16_t pick_force();
      q16_t r;
      case ($urandom_range(0, 7))
         0, 1, 2: r = $urandom;
         3, 4, 5: r = q16_t'($urandom) >>> $urandom_range(0, 28);
         6: begin
            case ($urandom_range(0, 6))
               0: r = F_MAX;
               1: r = F_MIN;
               2: r = 0;
               3: r = 1;
               4: r = -1;
               5: r = Q_ONE;
               default: r = -Q_ONE;
            endcase
         end
         default: r = $urandom_range(0, 262144) - 131072;
      endcase
      return r;
   endfunction

   function automatic logic [15:0] pick_time_step();
      case ($urandom_range(0, 3))
         0: return 16'hFFFF;
         1: return 16'h0000;
         2: return $urandom_range(1, 4096);
         default: return $urandom_range(0, 65535);
      endcase
   endfunction

   function automatic logic [31:0] pick_mass();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $urandom_range(16384, 262144);
         2: return $urandom_range(1, 255);
         3: return {$urandom_range(0, 65535), 16'h0000};
         4: return 32'h0000_0000;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   task automatic add_row(input bit write_csr, input logic [7:0] index,
                          input logic [31:0] value, input q16_t fx, input q16_t fy,
                          input bit known, input body_state_t known_state);
      plan_row_t row;
      row.write_csr   = write_csr;
      row.csr_index   = index;
      row.csr_value   = value;
      row.force_x     = fx;
      row.force_y     = fy;
      row.known       = known;
      row.known_state = known_state;
      directed_plan.push_back(row);
   endtask

   task automatic write_csr(input logic [7:0] index, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (index == REG_DT)
         step_dt = value[15:0];
      else if (index == REG_MASS)
         mass_reg = value;
      csr_writes++;
      @(posedge clock);
   endtask

   task automatic offer_force(input force_req_t f, input bit known,
                              input body_state_t known_state);
      body_state_t predicted;
      req_tvalid <= 1'b1;
      req_tdata  <= f;
      do @(posedge clock); while (!req_tready);
      predicted = advance_body(f.force_x, f.force_y);
      expected_q.push_back(known ? known_state : predicted);
      requests_sent++;
   endtask

   task automatic pace_sender();
      if (gaps_on) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(0, 24);
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, expected_q.size());
         $display("tb_velocity_verlet_step: done, errors");
         $finish;
      end
   end

   // response side: own stall pattern, plus a long hold-off on demand
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_seen != hold_ask) begin
         hold_seen  <= hold_ask;
         hold_left  <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else begin
         if (rx_run == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_run  = $urandom_range(1, 40);
         end
         rx_run = rx_run - 1;
         case (rx_mode)
            RX_FREE:   rsp_tready <= 1'b1;
            RX_HALF:   rsp_tready <= $urandom_range(0, 1);
            RX_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
            default:   rsp_tready <= 1'b0;
         endcase
      end
   end

   always @(posedge clock) begin
      body_state_t got;
      body_state_t want;
      int          k;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = body_state_t'(rsp_tdata);
         if (expected_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("response with no request outstanding: %h", got);
         end else begin
            want = expected_q.pop_front();
            results_checked++;
            for (k = 0; k < 6; k++) begin
               if (got[k*32 +: 32] !== want[k*32 +: 32]) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("response %0d %s: expected %h, got %h", results_checked,
                              field_name[k], want[k*32 +: 32], got[k*32 +: 32]);
               end
            end
         end
      end
   end

   initial begin
      force_req_t  f;
      int          phase;
      int          n;
      logic [15:0] dt_pick;
      logic [31:0] mass_pick;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero force first, then dt set to zero: position and velocity stay at zero
      add_row(0, REG_DT, 0, 0, 0, 1, still_body(0, 0));
      add_row(1, REG_DT, 0, Q_ONE, -Q_ONE, 1, still_body(Q_ONE, -Q_ONE));
      add_row(1, REG_MASS, 0, F_MAX, F_MIN, 1, still_body(F_MAX, F_MIN));
      add_row(0, REG_DT, 0, 0, 0, 1, still_body(0, 0));
      add_row(1, REG_MASS, 1, 1, -1, 1, still_body(Q_ONE, -Q_ONE));
      add_row(0, REG_DT, 0, F_MAX, F_MIN, 1, still_body(F_MAX, F_MIN));
      add_row(1, REG_SPARE_LO, 0, 2, -2, 1, still_body(2 * Q_ONE, -2 * Q_ONE));
      add_row(1, REG_SPARE_HI, 0, 3, -3, 1, still_body(3 * Q_ONE, -3 * Q_ONE));
      add_row(1, REG_MASS, 32'hFFFF_FFFF, F_MAX, F_MIN, 0, '0);
      add_row(1, REG_MASS, vvs_pkg::MASS_RESET, 32'sh8000, -32'sh8000, 1,
              still_body(32'sh8000, -32'sh8000));
      add_row(1, REG_DT, 16'hFFFF, F_MAX, F_MIN, 0, '0);
      add_row(0, REG_DT, 0, F_MAX, F_MIN, 0, '0);
      add_row(0, REG_DT, 0, F_MIN, F_MAX, 0, '0);
      add_row(1, REG_DT, 1, 1, -1, 0, '0);
      add_row(1, REG_MASS, 32'h0002_0000, 1, -1, 0, '0);
      add_row(1, REG_DT, vvs_pkg::DT_RESET, Q_ONE, -Q_ONE, 0, '0);
      add_row(1, REG_MASS, 1, 32'sh8000, -32'sh8000, 0, '0);
      add_row(1, REG_MASS, vvs_pkg::MASS_RESET, -1, 1, 0, '0);
      add_row(1, REG_DT, 16'h8000, 32'sh5555_5555, 32'shAAAA_AAAA, 0, '0);
      add_row(0, REG_DT, 0, 32'shAAAA_AAAA, 32'sh5555_5555, 0, '0);

      foreach (directed_plan[r]) begin
         if (directed_plan[r].write_csr) begin
            wait_for_results();
            write_csr(directed_plan[r].csr_index, directed_plan[r].csr_value);
         end
         f.force_x = directed_plan[r].force_x;
         f.force_y = directed_plan[r].force_y;
         offer_force(f, directed_plan[r].known, directed_plan[r].known_state);
         pace_sender();
      end

      for (phase = 0; phase < PHASES; phase++) begin
         wait_for_results();
         case (phase)
            0: begin
               dt_pick   = 16'hFFFF;
               mass_pick = 1;
            end
            1: begin
               dt_pick   = 16'h0000;
               mass_pick = 32'hFFFF_FFFF;
            end
            2: begin
               dt_pick   = 1;
               mass_pick = 0;
            end
            3: begin
               dt_pick   = vvs_pkg::DT_RESET;
               mass_pick = vvs_pkg::MASS_RESET;
            end
            default: begin
               dt_pick   = pick_time_step();
               mass_pick = pick_mass();
            end
         endcase
         write_csr(REG_DT, dt_pick);
         write_csr(REG_MASS, mass_pick);
         if (phase % 2 == 1)
            write_csr(REG_SPARE_LO, $urandom);
         gaps_on    = (phase != 4);
         burst_left = 0;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 3 && n == 40)
               hold_ask++;
            if (phase == 5 && n == 60)
               wait_for_results();
            f.force_x = pick_force();
            f.force_y = pick_force();
            offer_force(f, 1'b0, '0);
            pace_sender();
         end
      end

      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d force requests, %0d register writes: dt and mass extremes, zero mass,",
               requests_sent, csr_writes);
      $display("spare indexes, saturation and rounding ties; %0d responses checked",
               results_checked);
      if (mismatch_count == 0) begin
         $display("tb_velocity_verlet_step: done, clean");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("tb_velocity_verlet_step: done, errors");
      end
      $finish;
   end

endmodule
